>>> hw/rtl/utf8_to_cp1252_converter_defines.svh
// Assertion macros for the UTF-8 to Windows-1252 converter
`ifndef UTF8_TO_CP1252_CONVERTER_DEFINES_SVH
`define UTF8_TO_CP1252_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define U2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define U2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/u2c_pkg.sv
// Shared types, constants and decode functions for the UTF-8 to Windows-1252 converter
`timescale 1ns / 1ps
package u2c_pkg;

	localparam logic [7:0] REPL_RESET = 8'h3F;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       text_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // take an input item and start the scan
		logic advance;  // emit at the scan point and move on
		logic finish;   // release the pending result as the last of the item
		logic hold;     // keep the unfinished tail for the next item
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic at_end;    // scan point past the last byte
		logic act_hold;  // sequence at the scan point is unfinished and must be kept
		logic pend_v;    // a result is waiting to be released
		logic out_free;  // output register can take a result this cycle
	} dp_sts_t;

	// Sequence length from the lead byte, zero for a byte that cannot lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0)
			len = 3'd1;
		else if ((b & 8'hE0) == 8'hC0)
			len = 3'd2;
		else if ((b & 8'hF0) == 8'hE0)
			len = 3'd3;
		else if ((b & 8'hF8) == 8'hF0)
			len = 3'd4;
		else
			len = 3'd0;
		return len;
	endfunction

	// Code point to Windows-1252 byte
	function automatic logic [7:0] map_cp(input logic [20:0] cp, input logic [7:0] repl);
		logic [7:0] r;
		if (cp <= 21'h7F || (cp >= 21'hA0 && cp <= 21'hFF)) begin
			r = cp[7:0];
		end else begin
			case (cp)
				21'h20AC: r = 8'h80;
				21'h201A: r = 8'h82;
				21'h0192: r = 8'h83;
				21'h201E: r = 8'h84;
				21'h2026: r = 8'h85;
				21'h2020: r = 8'h86;
				21'h2021: r = 8'h87;
				21'h02C6: r = 8'h88;
				21'h2030: r = 8'h89;
				21'h0160: r = 8'h8A;
				21'h2039: r = 8'h8B;
				21'h0152: r = 8'h8C;
				21'h017D: r = 8'h8E;
				21'h2018: r = 8'h91;
				21'h2019: r = 8'h92;
				21'h201C: r = 8'h93;
				21'h201D: r = 8'h94;
				21'h2022: r = 8'h95;
				21'h2013: r = 8'h96;
				21'h2014: r = 8'h97;
				21'h02DC: r = 8'h98;
				21'h2122: r = 8'h99;
				21'h0161: r = 8'h9A;
				21'h203A: r = 8'h9B;
				21'h0153: r = 8'h9C;
				21'h017E: r = 8'h9E;
				21'h0178: r = 8'h9F;
				default:  r = repl;
			endcase
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/u2c_dp.sv
// Datapath: held bytes, scan window, decode and output register
`timescale 1ns / 1ps
module u2c_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  u2c_pkg::in_item_t  in_data,
	output u2c_pkg::out_item_t out_data,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  u2c_pkg::dp_cmd_t   cmd,
	output u2c_pkg::dp_sts_t   sts
);
	import u2c_pkg::*;

	logic [7:0]       repl_q;
	logic [2:0][7:0]  held_q;
	logic [1:0]       held_cnt_q;
	logic [3:0][7:0]  seq_q;
	logic [2:0]       n_q;
	logic [2:0]       p_q;
	logic             fin_q;
	logic [7:0]       pend_q;
	logic             pend_v_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic [3:0][7:0]  win;
	logic [2:0]       avail;
	logic [2:0]       len;
	logic             bad;
	logic             trunc;
	logic [20:0]      cp;
	logic [7:0]       emit_byte;
	logic [2:0]       step;
	logic             push;

	// Window starts at the scan point
	assign win   = seq_q >> {p_q[1:0], 3'b000};
	assign avail = n_q - p_q;
	assign len   = seq_len(win[0]);

	always_comb begin
		bad = 1'b0;
		for (int k = 1; k < 4; k++) begin
			if (3'(k) < len && 3'(k) < avail && win[k][7:6] != 2'b10)
				bad = 1'b1;
		end
	end

	assign trunc = len > avail;

	always_comb begin
		case (len)
			3'd2:    cp = {10'd0, win[0][4:0], win[1][5:0]};
			3'd3:    cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
			default: cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
		endcase
	end

	always_comb begin
		if (len == 3'd0 || bad || trunc) begin
			emit_byte = repl_q;
			step      = 3'd1;
		end else if (len == 3'd1) begin
			emit_byte = win[0];
			step      = 3'd1;
		end else begin
			emit_byte = map_cp(cp, repl_q);
			step      = len;
		end
	end

	assign sts.at_end   = p_q >= n_q;
	assign sts.act_hold = (len >= 3'd2) && !bad && trunc && !fin_q;
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign push = pend_v_q && (cmd.advance || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_wr_en) begin
			repl_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q  <= 2'd0;
			n_q         <= 3'd0;
			p_q         <= 3'd0;
			fin_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				held_cnt_q <= 2'd0;
				n_q        <= {1'b0, held_cnt_q} + 3'd1;
				p_q        <= 3'd0;
				fin_q      <= in_data.text_end;
				pend_v_q   <= 1'b0;
			end
			if (cmd.advance) begin
				p_q      <= p_q + step;
				pend_v_q <= 1'b1;
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
				if (cmd.hold)
					held_cnt_q <= avail[1:0];
			end
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++)
				seq_q[i] <= (2'(i) == held_cnt_q) ? in_data.in_byte : held_q[i];
			seq_q[3] <= in_data.in_byte;
		end
		if (cmd.advance)
			pend_q <= emit_byte;
		if (cmd.finish && cmd.hold) begin
			for (int i = 0; i < 3; i++)
				held_q[i] <= win[i];
		end
		if (push) begin
			out_q.out_byte  <= pend_q;
			out_q.run_last  <= cmd.finish;
			out_q.text_done <= cmd.finish && fin_q;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/u2c_ctrl.sv
// Controller: accepts items and steps the scan one result at a time
`timescale 1ns / 1ps
module u2c_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  u2c_pkg::dp_sts_t sts,
	output u2c_pkg::dp_cmd_t cmd
);
	import u2c_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   can_push;

	// A new result may go out once any waiting one has somewhere to land
	assign can_push = !sts.pend_v || sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if ((sts.at_end || sts.act_hold) && can_push)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				if (sts.at_end || sts.act_hold) begin
					cmd.finish = can_push;
					cmd.hold   = can_push && !sts.at_end;
				end else begin
					cmd.advance = can_push;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/utf8_to_cp1252_converter.sv
// Top level of the UTF-8 to Windows-1252 converter
//
// Takes one UTF-8 byte per item and returns zero to four Windows-1252 bytes
// for it. Once an item is taken, the scan unit walks the up to four bytes on
// hand (held tail plus the new byte) and produces one result per cycle when
// the output side keeps up, from the single decode-and-map step of the scan.
// Each result waits in a pending register so the last one of an item can
// carry run_last; text_done marks the last result of a final item.
// The replacement byte (reset 0x3F) is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "utf8_to_cp1252_converter_defines.svh"
module utf8_to_cp1252_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  u2c_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output u2c_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data
);
	import u2c_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	u2c_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	u2c_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.out_data    (out_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);

	`U2C_ASSERT_NOW(a_no_pend_on_accept, clk, arst_n, in_valid && in_ready, !sts.pend_v, "item accepted while a result is still pending")
	`U2C_ASSERT_NOW(a_adv_fin_excl, clk, arst_n, cmd.advance, !cmd.finish && !cmd.hold, "advance and finish issued together")
	`U2C_ASSERT_NEXT(a_finish_clears, clk, arst_n, cmd.finish, !sts.pend_v && in_ready, "pending result left after finish")
	`U2C_ASSERT_NEXT(a_advance_pends, clk, arst_n, cmd.advance, sts.pend_v && !in_ready, "advance did not leave a pending result")

endmodule

>>> test/cp1252_stream_checker.sv
// Stream checker for the UTF-8 to Windows-1252 converter: predicts output bytes and compares them
`timescale 1ns / 1ps
module cp1252_stream_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  u2c_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  u2c_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	output int                 expected_left,
	output int                 fail_count
);
	import u2c_pkg::*;

	out_item_t   pending_cp1252[$];
	logic [7:0]  held_q [3];
	int          held_n;
	logic [7:0]  repl;

	initial fail_count = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// Number of bytes in the sequence this byte starts, zero if it cannot start one
	function automatic int lead_length(input logic [7:0] b);
		int len;
		if (b[7] == 1'b0)
			len = 1;
		else if (b[7:5] == 3'b110)
			len = 2;
		else if (b[7:4] == 4'b1110)
			len = 3;
		else if (b[7:3] == 5'b11110)
			len = 4;
		else
			len = 0;
		return len;
	endfunction

	function automatic logic [7:0] cp1252_of(input logic [20:0] cp, input logic [7:0] fallback);
		logic [7:0] b;
		b = fallback;
		if (cp < 21'h80 || (cp >= 21'hA0 && cp < 21'h100)) begin
			b = cp[7:0];
		end else if (cp[20:16] == 5'd0) begin
			case (cp[15:0])
				16'h20AC: b = 8'h80;
				16'h201A: b = 8'h82;
				16'h0192: b = 8'h83;
				16'h201E: b = 8'h84;
				16'h2026: b = 8'h85;
				16'h2020: b = 8'h86;
				16'h2021: b = 8'h87;
				16'h02C6: b = 8'h88;
				16'h2030: b = 8'h89;
				16'h0160: b = 8'h8A;
				16'h2039: b = 8'h8B;
				16'h0152: b = 8'h8C;
				16'h017D: b = 8'h8E;
				16'h2018: b = 8'h91;
				16'h2019: b = 8'h92;
				16'h201C: b = 8'h93;
				16'h201D: b = 8'h94;
				16'h2022: b = 8'h95;
				16'h2013: b = 8'h96;
				16'h2014: b = 8'h97;
				16'h02DC: b = 8'h98;
				16'h2122: b = 8'h99;
				16'h0161: b = 8'h9A;
				16'h203A: b = 8'h9B;
				16'h0153: b = 8'h9C;
				16'h017E: b = 8'h9E;
				16'h0178: b = 8'h9F;
				default:  b = fallback;
			endcase
		end
		return b;
	endfunction

	// Scan the held tail plus the new byte and queue the bytes it yields
	task automatic transcode_byte(input in_item_t item);
		logic [7:0]  seq [4];
		logic [7:0]  emitted [4];
		int          n, p, len, k, nres;
		logic        broken;
		logic [20:0] cp;
		out_item_t   res;
		n = held_n;
		for (k = 0; k < n; k++)
			seq[k] = held_q[k];
		seq[n] = item.in_byte;
		n = n + 1;
		held_n = 0;
		nres = 0;
		p = 0;
		while (p < n) begin
			len = lead_length(seq[p]);
			broken = 1'b0;
			for (k = 1; k < len && p + k < n; k++)
				if (seq[p + k][7:6] != 2'b10)
					broken = 1'b1;
			if (len == 1) begin
				emitted[nres] = seq[p];
				nres = nres + 1;
				p = p + 1;
			end else if (len == 0 || broken || (p + len > n && item.text_end)) begin
				// lead gives way to the replacement, rescan what follows it
				emitted[nres] = repl;
				nres = nres + 1;
				p = p + 1;
			end else if (p + len > n) begin
				for (k = 0; p + k < n; k++)
					held_q[k] = seq[p + k];
				held_n = n - p;
				p = n;
			end else begin
				case (len)
					2: cp = {10'd0, seq[p][4:0], seq[p + 1][5:0]};
					3: cp = {5'd0, seq[p][3:0], seq[p + 1][5:0], seq[p + 2][5:0]};
					default: cp = {seq[p][2:0], seq[p + 1][5:0], seq[p + 2][5:0], seq[p + 3][5:0]};
				endcase
				emitted[nres] = cp1252_of(cp, repl);
				nres = nres + 1;
				p = p + len;
			end
		end
		for (k = 0; k < nres; k++) begin
			res.out_byte  = emitted[k];
			res.run_last  = (k == nres - 1);
			res.text_done = (k == nres - 1) && item.text_end;
			pending_cp1252.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			held_n = 0;
			repl = REPL_RESET;
			pending_cp1252.delete();
			expected_left <= 0;
		end else begin
			if (cfg_wr_en)
				repl = cfg_wr_data;
			if (in_valid && in_ready)
				transcode_byte(in_data);
			if (out_valid && out_ready) begin
				if (pending_cp1252.size() == 0) begin
					report_mismatch($sformatf("unexpected item byte=%h last=%b done=%b",
						out_data.out_byte, out_data.run_last, out_data.text_done));
				end else begin
					want = pending_cp1252.pop_front();
					if (out_data.out_byte != want.out_byte)
						report_mismatch($sformatf("out_byte %h, want %h",
							out_data.out_byte, want.out_byte));
					if (out_data.run_last != want.run_last)
						report_mismatch($sformatf("run_last %b, want %b (byte %h)",
							out_data.run_last, want.run_last, want.out_byte));
					if (out_data.text_done != want.text_done)
						report_mismatch($sformatf("text_done %b, want %b (byte %h)",
							out_data.text_done, want.text_done, want.out_byte));
				end
			end
			expected_left <= pending_cp1252.size();
		end
	end

endmodule

>>> test/utf8_to_cp1252_converter_test.sv
// Testbench top for the UTF-8 to Windows-1252 converter: stimulus, stalls and verdict
`timescale 1ns / 1ps
module utf8_to_cp1252_converter_test;
	import u2c_pkg::*;

	localparam int SETTLE_CYCLES = 10;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	int          expected_left;
	int          fail_count;

	int          burst_left = 0;
	int          bytes_sent = 0;
	int          ready_pct = 100;
	int          ready_span = 0;

	// {text_end, byte}: plain and bad bytes, decoded and overlong forms, cut-off runs
	logic [8:0] opening [27] = '{
		9'h000, 9'h07F, 9'h080, 9'h0FF,
		9'h0C3, 9'h0A9,
		9'h0E2, 9'h082, 9'h0AC,
		9'h0C0, 9'h080,
		9'h0C2, 9'h081,
		9'h0F0, 9'h09F, 9'h098, 9'h041,
		9'h0E2, 9'h041,
		9'h0E2, 9'h182,
		9'h0F0, 9'h080, 9'h080, 9'h180,
		9'h0C5, 9'h1B8
	};

	logic [20:0] win_points [27] = '{
		21'h20AC, 21'h201A, 21'h0192, 21'h201E, 21'h2026, 21'h2020, 21'h2021,
		21'h02C6, 21'h2030, 21'h0160, 21'h2039, 21'h0152, 21'h017D, 21'h2018,
		21'h2019, 21'h201C, 21'h201D, 21'h2022, 21'h2013, 21'h2014, 21'h02DC,
		21'h2122, 21'h0161, 21'h203A, 21'h0153, 21'h017E, 21'h0178
	};

	utf8_to_cp1252_converter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	cp1252_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.expected_left (expected_left),
		.fail_count    (fail_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Receiver: readiness level is picked anew at the end of each random span
	always @(posedge clk) begin
		if (ready_span == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct = 100;
				1: ready_pct = 80;
				2: ready_pct = 40;
				default: ready_pct = 10;
			endcase
			ready_span = $urandom_range(20, 80);
		end else begin
			ready_span = ready_span - 1;
		end
		out_ready <= ($urandom_range(1, 100) <= ready_pct);
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic coin_end();
		return $urandom_range(0, 15) == 0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, text_end: fin};
		do @(posedge clk); while (!in_ready);
		burst_left--;
		bytes_sent++;
	endtask

	// Shortest encoding of a code point
	task automatic send_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			send_byte(cp[7:0], coin_end());
		end else if (cp < 21'h800) begin
			send_byte({3'b110, cp[10:6]}, coin_end());
			send_byte({2'b10, cp[5:0]}, coin_end());
		end else if (cp < 21'h10000) begin
			send_byte({4'b1110, cp[15:12]}, coin_end());
			send_byte({2'b10, cp[11:6]}, coin_end());
			send_byte({2'b10, cp[5:0]}, coin_end());
		end else begin
			send_byte({5'b11110, cp[20:18]}, coin_end());
			send_byte({2'b10, cp[17:12]}, coin_end());
			send_byte({2'b10, cp[11:6]}, coin_end());
			send_byte({2'b10, cp[5:0]}, coin_end());
		end
	endtask

	task automatic send_lead(input int len);
		case (len)
			2: send_byte(8'hC0 | 8'($urandom_range(0, 31)), coin_end());
			3: send_byte(8'hE0 | 8'($urandom_range(0, 15)), coin_end());
			default: send_byte(8'hF0 | 8'($urandom_range(0, 7)), coin_end());
		endcase
	endtask

	task automatic send_random_run();
		int pick, len, k, sel;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_byte(8'($urandom_range(0, 127)), coin_end());
		end else if (pick < 58) begin
			// well-formed run with random payload, overlong forms included
			len = (pick < 35) ? 2 : (pick < 50) ? 3 : 4;
			send_lead(len);
			for (k = 1; k < len; k++)
				send_byte(8'h80 | 8'($urandom_range(0, 63)), coin_end());
		end else if (pick < 75) begin
			sel = $urandom_range(0, 39);
			if (sel < 27)
				send_point(win_points[sel]);
			else if (sel < 35)
				send_point(21'($urandom_range(8'hA0, 8'hFF)));
			else
				send_point(21'($urandom_range(21'h80, 21'h1FFFFF)));
		end else if (pick < 88) begin
			// cut-off run, often followed by an ASCII or continuation byte
			len = $urandom_range(2, 4);
			send_lead(len);
			for (k = 0; k < $urandom_range(0, len - 2); k++)
				send_byte(8'h80 | 8'($urandom_range(0, 63)), coin_end());
			if ($urandom_range(0, 2) != 0)
				send_byte(8'($urandom_range(0, 255)) & 8'hBF, coin_end());
		end else begin
			send_byte(8'($urandom_range(0, 255)), coin_end());
		end
	endtask

	// Hold input until every expected byte is out and the scan has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_repl(input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_random_run();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 27; i++)
			send_byte(opening[i][7:0], opening[i][8]);
		settle();

		write_repl(8'h00);
		random_phase(45);
		settle();

		write_repl(8'hFF);
		random_phase(45);
		settle();

		write_repl(8'($urandom_range(1, 254)));
		random_phase(40);
		settle();

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/u2c_pkg.sv
hw/rtl/u2c_dp.sv
hw/rtl/u2c_ctrl.sv
hw/rtl/utf8_to_cp1252_converter.sv
test/cp1252_stream_checker.sv
test/utf8_to_cp1252_converter_test.sv
